>>> design/mcpic_pkg.sv
// Shared types, codes and the sequencer program of the motor current PI mode controller.
package mcpic_pkg;

    typedef enum logic [1:0]
    {
        ACT_TICK,
        ACT_START,
        ACT_CLEAR,
        ACT_NONE
    } action_t;

    typedef enum logic [1:0]
    {
        MODE_IDLE,
        MODE_FIXED,
        MODE_TEST,
        MODE_BUZZ
    } mode_t;

    typedef enum logic [2:0]
    {
        REG_PROP_GAIN,
        REG_INTEGRAL_GAIN,
        REG_INTEGRAL_LIMIT,
        REG_FIXED_DUTY,
        REG_TEST_AMPLITUDE,
        REG_BUZZ_AMPLITUDE,
        REG_BUZZ_PHASE_STEP,
        REG_TARGET_LIMIT
    } cfg_reg_t;

    localparam int CFG_W = 22;

    localparam logic signed [15:0] DUTY_MAX = 16'sd25600;

    localparam longint SIN_A = 51472;
    localparam longint SIN_B = 21024;
    localparam longint SIN_C = 2320;

    typedef enum logic [4:0]
    {
        U_NOP,
        U_START,
        U_CLEAR,
        U_OUT_ZERO,
        U_OUT_FIXED,
        U_TEST_TARGET,
        U_BUZZ_ADV,
        U_MUL_K,
        U_ROM_ADDR,
        U_ROM_READ,
        U_MUL_AMP,
        U_BUZZ_TARGET,
        U_ERR,
        U_INTEG,
        U_MUL_P,
        U_MUL_I,
        U_SUM,
        U_OUT_PI,
        U_BUZZ_END
    } uop_t;

    typedef enum logic [3:0]
    {
        C_NEXT,
        C_JUMP,
        C_WAIT_IN,
        C_ACT_START,
        C_ACT_CLEAR,
        C_ACT_NONE,
        C_MODE_FIXED,
        C_MODE_TEST,
        C_MODE_BUZZ,
        C_BUZZ_DONE
    } cond_t;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t PC_IDLE      = 5'd0;
    localparam upc_t PC_CHK_START = 5'd1;
    localparam upc_t PC_CHK_CLEAR = 5'd2;
    localparam upc_t PC_CHK_NONE  = 5'd3;
    localparam upc_t PC_CHK_FIXED = 5'd4;
    localparam upc_t PC_CHK_TEST  = 5'd5;
    localparam upc_t PC_CHK_BUZZ  = 5'd6;
    localparam upc_t PC_OUT_ZERO  = 5'd7;
    localparam upc_t PC_START     = 5'd8;
    localparam upc_t PC_CLEAR     = 5'd9;
    localparam upc_t PC_FIXED     = 5'd10;
    localparam upc_t PC_TEST      = 5'd11;
    localparam upc_t PC_BUZZ      = 5'd12;
    localparam upc_t PC_BUZZ_ADV  = 5'd13;
    localparam upc_t PC_MUL_K     = 5'd14;
    localparam upc_t PC_ROM_ADDR  = 5'd15;
    localparam upc_t PC_ROM_READ  = 5'd16;
    localparam upc_t PC_MUL_AMP   = 5'd17;
    localparam upc_t PC_BUZZ_TGT  = 5'd18;
    localparam upc_t PC_PI        = 5'd19;
    localparam upc_t PC_INTEG     = 5'd20;
    localparam upc_t PC_MUL_P     = 5'd21;
    localparam upc_t PC_MUL_I     = 5'd22;
    localparam upc_t PC_SUM       = 5'd23;
    localparam upc_t PC_OUT_PI    = 5'd24;
    localparam upc_t PC_BUZZ_END  = 5'd25;

    typedef struct packed
    {
        uop_t  uop;
        cond_t cond;
        logic  wait_out;
        upc_t  target;
    } uword_t;

    function automatic uword_t mk_word(input uop_t uop, input cond_t cond,
                                       input logic wait_out, input upc_t target);
        uword_t w;
        w.uop      = uop;
        w.cond     = cond;
        w.wait_out = wait_out;
        w.target   = target;
        return w;
    endfunction

    // Steps that write the result register wait there while the previous item is still held.
    function automatic uword_t ucode_word(input upc_t pc);
        uword_t w;
        unique case (pc)
            PC_IDLE:      w = mk_word(U_NOP,         C_WAIT_IN,    1'b0, PC_CHK_START);
            PC_CHK_START: w = mk_word(U_NOP,         C_ACT_START,  1'b0, PC_START);
            PC_CHK_CLEAR: w = mk_word(U_NOP,         C_ACT_CLEAR,  1'b0, PC_CLEAR);
            PC_CHK_NONE:  w = mk_word(U_NOP,         C_ACT_NONE,   1'b0, PC_IDLE);
            PC_CHK_FIXED: w = mk_word(U_NOP,         C_MODE_FIXED, 1'b0, PC_FIXED);
            PC_CHK_TEST:  w = mk_word(U_NOP,         C_MODE_TEST,  1'b0, PC_TEST);
            PC_CHK_BUZZ:  w = mk_word(U_NOP,         C_MODE_BUZZ,  1'b0, PC_BUZZ);
            PC_OUT_ZERO:  w = mk_word(U_OUT_ZERO,    C_JUMP,       1'b1, PC_IDLE);
            PC_START:     w = mk_word(U_START,       C_JUMP,       1'b0, PC_IDLE);
            PC_CLEAR:     w = mk_word(U_CLEAR,       C_JUMP,       1'b0, PC_IDLE);
            PC_FIXED:     w = mk_word(U_OUT_FIXED,   C_JUMP,       1'b1, PC_IDLE);
            PC_TEST:      w = mk_word(U_TEST_TARGET, C_JUMP,       1'b0, PC_PI);
            PC_BUZZ:      w = mk_word(U_NOP,         C_BUZZ_DONE,  1'b0, PC_BUZZ_END);
            PC_BUZZ_ADV:  w = mk_word(U_BUZZ_ADV,    C_NEXT,       1'b0, PC_IDLE);
            PC_MUL_K:     w = mk_word(U_MUL_K,       C_NEXT,       1'b0, PC_IDLE);
            PC_ROM_ADDR:  w = mk_word(U_ROM_ADDR,    C_NEXT,       1'b0, PC_IDLE);
            PC_ROM_READ:  w = mk_word(U_ROM_READ,    C_NEXT,       1'b0, PC_IDLE);
            PC_MUL_AMP:   w = mk_word(U_MUL_AMP,     C_NEXT,       1'b0, PC_IDLE);
            PC_BUZZ_TGT:  w = mk_word(U_BUZZ_TARGET, C_NEXT,       1'b0, PC_IDLE);
            PC_PI:        w = mk_word(U_ERR,         C_NEXT,       1'b0, PC_IDLE);
            PC_INTEG:     w = mk_word(U_INTEG,       C_NEXT,       1'b0, PC_IDLE);
            PC_MUL_P:     w = mk_word(U_MUL_P,       C_NEXT,       1'b0, PC_IDLE);
            PC_MUL_I:     w = mk_word(U_MUL_I,       C_NEXT,       1'b0, PC_IDLE);
            PC_SUM:       w = mk_word(U_SUM,         C_NEXT,       1'b0, PC_IDLE);
            PC_OUT_PI:    w = mk_word(U_OUT_PI,      C_JUMP,       1'b1, PC_IDLE);
            PC_BUZZ_END:  w = mk_word(U_BUZZ_END,    C_JUMP,       1'b0, PC_OUT_ZERO);
            default:      w = mk_word(U_NOP,         C_JUMP,       1'b0, PC_IDLE);
        endcase
        return w;
    endfunction

endpackage

>>> design/motor_current_pi_mode_controller.sv
// Motor current PI mode controller: microcoded sequencer around one shared multiplier.
// Each tick yields one result: zero in idle and when buzz ends, the saturated fixed duty in fixed PWM,
// and the PI output in current test and buzz, whose program steps use the shared multiplier.
// A new item is accepted only while the sequencer is at its idle step, so it is not taken before
// the previous one is done; start, clear and the unused action return to idle with no result.
// Reset is asynchronous and active low; it restores the register defaults and clears the block state.
module motor_current_pi_mode_controller
    import mcpic_pkg::*;
#(
    parameter int TEST_SAMPLES     = 128,
    parameter int TEST_SEGMENT     = 32,
    parameter int SINE_TABLE_DEPTH = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           action,
    input  logic [1:0]           new_mode,
    input  logic [15:0]          buzz_ticks,
    input  logic signed [12:0]   measured_current,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [15:0]   duty,
    output logic signed [12:0]   target_current,
    output logic [1:0]           mode_after,
    output logic                 test_sample_valid,
    output logic [6:0]           test_sample_index,
    input  logic                 cfg_write,
    input  logic [2:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IW = $clog2(TEST_SAMPLES);
    localparam int SW = (TEST_SEGMENT > 1) ? $clog2(TEST_SEGMENT) : 1;
    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam logic [AW-1:0] DEPTH_A = AW'(SINE_TABLE_DEPTH);

    function automatic logic [15:0] sine_entry(input int k);
        longint x;
        longint x2;
        longint t;
        x  = (longint'(k) * 64'sd32768) / SINE_TABLE_DEPTH;
        x2 = (x * x) >>> 15;
        t  = SIN_B - ((SIN_C * x2) >>> 15);
        t  = SIN_A - ((t * x2) >>> 15);
        return 16'((t * x) >>> 15);
    endfunction

    logic [15:0] sine_rom [SINE_TABLE_DEPTH+1];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++)
    begin : g_sine_rom
        assign sine_rom[g] = sine_entry(g);
    end

    // Configuration registers.
    logic signed [15:0] prop_gain_reg;
    logic signed [15:0] integral_gain_reg;
    logic [21:0]        integral_limit_reg;
    logic signed [15:0] fixed_duty_reg;
    logic [11:0]        test_amplitude_reg;
    logic [11:0]        buzz_amplitude_reg;
    logic [15:0]        buzz_phase_step_reg;
    logic [11:0]        target_limit_reg;

    // Sequencer and block state.
    upc_t               pc_reg, pc_next;
    mode_t              mode_reg, mode_next;
    logic signed [22:0] integ_reg, integ_next;
    logic [15:0]        phase_reg, phase_next;
    logic [IW-1:0]      tidx_reg, tidx_next;
    logic [SW-1:0]      seg_cnt_reg, seg_cnt_next;
    logic               seg_odd_reg, seg_odd_next;
    logic [15:0]        buzz_rem_reg, buzz_rem_next;
    logic               out_valid_reg, out_valid_next;

    // Item and datapath registers.
    action_t            action_reg;
    logic [1:0]         new_mode_reg;
    logic [15:0]        buzz_ticks_reg;
    logic signed [12:0] meas_reg;
    logic signed [12:0] targ_reg, targ_next;
    logic signed [13:0] err_reg, err_next;
    logic signed [40:0] prod_reg, prod_next;
    logic signed [41:0] sum_reg, sum_next;
    logic [AW-1:0]      rom_addr_reg, rom_addr_next;
    logic [15:0]        sine_reg;

    // Result registers.
    logic signed [15:0] duty_reg, duty_next;
    logic signed [12:0] target_out_reg, target_out_next;
    mode_t              mode_after_reg, mode_after_next;
    logic               sample_valid_reg, sample_valid_next;
    logic [6:0]         sample_index_reg, sample_index_next;

    uword_t             uw;
    logic               in_accept;
    logic               step_hold;
    logic               out_write;
    logic               take_jump;

    logic signed [23:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [40:0] mul_p;

    logic [AW-1:0]      k_idx;
    logic [11:0]        mag;
    logic [11:0]        mag_clip;
    logic signed [12:0] mag13;
    logic signed [12:0] amp13;
    logic signed [23:0] isum;
    logic signed [23:0] lim24;
    logic signed [15:0] fixed_sat;
    logic signed [15:0] duty_sat;
    logic               test_last;
    logic               seg_last;

    assign uw        = ucode_word(pc_reg);
    assign in_stall  = (pc_reg != PC_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign step_hold = uw.wait_out && out_valid_reg && out_stall;
    assign out_write = uw.wait_out && !step_hold;

    assign out_valid         = out_valid_reg;
    assign duty              = duty_reg;
    assign target_current    = target_out_reg;
    assign mode_after        = mode_after_reg;
    assign test_sample_valid = sample_valid_reg;
    assign test_sample_index = sample_index_reg;

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (uw.uop)
            U_MUL_K:
            begin
                mul_a = $signed({10'b0, phase_reg[13:0]});
                mul_b = $signed(17'(SINE_TABLE_DEPTH));
            end
            U_MUL_AMP:
            begin
                mul_a = $signed({12'b0, buzz_amplitude_reg});
                mul_b = $signed({1'b0, sine_reg});
            end
            U_MUL_P:
            begin
                mul_a = 24'(err_reg);
                mul_b = 17'(prop_gain_reg);
            end
            U_MUL_I:
            begin
                mul_a = 24'(integ_reg);
                mul_b = 17'(integral_gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign k_idx    = prod_reg[14 +: AW];
    assign mag      = prod_reg[26:15];
    assign mag_clip = (mag > target_limit_reg) ? target_limit_reg : mag;
    assign mag13    = $signed({1'b0, mag_clip});
    assign amp13    = $signed({1'b0, test_amplitude_reg});
    assign isum     = 24'(integ_reg) + 24'(err_reg);
    assign lim24    = $signed({2'b00, integral_limit_reg});

    assign fixed_sat = (fixed_duty_reg > DUTY_MAX)  ? DUTY_MAX :
                       (fixed_duty_reg < -DUTY_MAX) ? -DUTY_MAX : fixed_duty_reg;
    assign duty_sat  = (sum_reg > 42'(DUTY_MAX))  ? DUTY_MAX :
                       (sum_reg < -42'(DUTY_MAX)) ? -DUTY_MAX : 16'(sum_reg);

    assign test_last = (tidx_reg == IW'(TEST_SAMPLES - 1));
    assign seg_last  = (seg_cnt_reg == SW'(TEST_SEGMENT - 1));

    // Step counter and conditional jumps.
    always_comb
    begin
        unique case (uw.cond)
            C_NEXT:       take_jump = 1'b0;
            C_JUMP:       take_jump = 1'b1;
            C_WAIT_IN:    take_jump = in_accept;
            C_ACT_START:  take_jump = (action_reg == ACT_START);
            C_ACT_CLEAR:  take_jump = (action_reg == ACT_CLEAR);
            C_ACT_NONE:   take_jump = (action_reg == ACT_NONE);
            C_MODE_FIXED: take_jump = (mode_reg == MODE_FIXED);
            C_MODE_TEST:  take_jump = (mode_reg == MODE_TEST);
            C_MODE_BUZZ:  take_jump = (mode_reg == MODE_BUZZ);
            C_BUZZ_DONE:  take_jump = (buzz_rem_reg == '0);
            default:      take_jump = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (step_hold)
            pc_next = pc_reg;
        else if (take_jump)
            pc_next = uw.target;
        else if (uw.cond == C_WAIT_IN)
            pc_next = pc_reg;
        else
            pc_next = pc_reg + 1'b1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_write)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    // Datapath driven by the current control word.
    always_comb
    begin
        mode_next         = mode_reg;
        integ_next        = integ_reg;
        phase_next        = phase_reg;
        tidx_next         = tidx_reg;
        seg_cnt_next      = seg_cnt_reg;
        seg_odd_next      = seg_odd_reg;
        buzz_rem_next     = buzz_rem_reg;
        targ_next         = targ_reg;
        err_next          = err_reg;
        prod_next         = prod_reg;
        sum_next          = sum_reg;
        rom_addr_next     = rom_addr_reg;
        duty_next         = duty_reg;
        target_out_next   = target_out_reg;
        mode_after_next   = mode_after_reg;
        sample_valid_next = sample_valid_reg;
        sample_index_next = sample_index_reg;

        if (!step_hold)
        begin
            unique case (uw.uop)
                U_NOP, U_ROM_READ:
                begin
                    mode_next = mode_reg;
                end
                U_START:
                begin
                    mode_next = mode_t'(new_mode_reg);
                    if (mode_t'(new_mode_reg) == MODE_BUZZ)
                        buzz_rem_next = buzz_ticks_reg;
                end
                U_CLEAR:
                begin
                    integ_next   = '0;
                    phase_next   = '0;
                    tidx_next    = '0;
                    seg_cnt_next = '0;
                    seg_odd_next = 1'b0;
                end
                U_OUT_ZERO:
                begin
                    duty_next         = '0;
                    target_out_next   = '0;
                    mode_after_next   = mode_reg;
                    sample_valid_next = 1'b0;
                    sample_index_next = '0;
                end
                U_OUT_FIXED:
                begin
                    duty_next         = fixed_sat;
                    target_out_next   = '0;
                    mode_after_next   = mode_reg;
                    sample_valid_next = 1'b0;
                    sample_index_next = '0;
                end
                U_TEST_TARGET:
                begin
                    targ_next = seg_odd_reg ? amp13 : -amp13;
                    if (seg_cnt_reg == '0)
                        integ_next = '0;
                end
                U_BUZZ_ADV:
                begin
                    buzz_rem_next = buzz_rem_reg - 1'b1;
                    phase_next    = phase_reg + buzz_phase_step_reg;
                end
                U_MUL_K:
                begin
                    prod_next = mul_p;
                end
                U_ROM_ADDR:
                begin
                    rom_addr_next = phase_reg[14] ? (DEPTH_A - k_idx) : k_idx;
                end
                U_MUL_AMP:
                begin
                    prod_next = mul_p;
                end
                U_BUZZ_TARGET:
                begin
                    targ_next = phase_reg[15] ? -mag13 : mag13;
                end
                U_ERR:
                begin
                    err_next = 14'(targ_reg) - 14'(meas_reg);
                end
                U_INTEG:
                begin
                    priority if (isum > lim24)
                        integ_next = 23'(lim24);
                    else if (isum < -lim24)
                        integ_next = 23'(-lim24);
                    else
                        integ_next = 23'(isum);
                end
                U_MUL_P:
                begin
                    prod_next = mul_p;
                end
                U_MUL_I:
                begin
                    sum_next  = 42'(prod_reg);
                    prod_next = mul_p;
                end
                U_SUM:
                begin
                    sum_next = sum_reg + 42'(prod_reg);
                end
                U_OUT_PI:
                begin
                    duty_next         = duty_sat;
                    target_out_next   = targ_reg;
                    mode_after_next   = mode_reg;
                    sample_valid_next = 1'b0;
                    sample_index_next = '0;
                    if (mode_reg == MODE_TEST)
                    begin
                        sample_valid_next = 1'b1;
                        sample_index_next = 7'(tidx_reg);
                        if (test_last)
                        begin
                            tidx_next       = '0;
                            seg_cnt_next    = '0;
                            seg_odd_next    = 1'b0;
                            integ_next      = '0;
                            mode_next       = MODE_IDLE;
                            mode_after_next = MODE_IDLE;
                        end
                        else
                        begin
                            tidx_next = tidx_reg + 1'b1;
                            if (seg_last)
                            begin
                                seg_cnt_next = '0;
                                seg_odd_next = !seg_odd_reg;
                            end
                            else
                            begin
                                seg_cnt_next = seg_cnt_reg + 1'b1;
                            end
                        end
                    end
                end
                U_BUZZ_END:
                begin
                    mode_next = MODE_IDLE;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg       <= '0;
            integral_gain_reg   <= '0;
            integral_limit_reg  <= 22'd65535;
            fixed_duty_reg      <= '0;
            test_amplitude_reg  <= 12'd200;
            buzz_amplitude_reg  <= 12'd120;
            buzz_phase_step_reg <= 16'd1074;
            target_limit_reg    <= 12'd4095;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PROP_GAIN:       prop_gain_reg       <= cfg_data[15:0];
                REG_INTEGRAL_GAIN:   integral_gain_reg   <= cfg_data[15:0];
                REG_INTEGRAL_LIMIT:  integral_limit_reg  <= cfg_data[21:0];
                REG_FIXED_DUTY:      fixed_duty_reg      <= cfg_data[15:0];
                REG_TEST_AMPLITUDE:  test_amplitude_reg  <= cfg_data[11:0];
                REG_BUZZ_AMPLITUDE:  buzz_amplitude_reg  <= cfg_data[11:0];
                REG_BUZZ_PHASE_STEP: buzz_phase_step_reg <= cfg_data[15:0];
                REG_TARGET_LIMIT:    target_limit_reg    <= cfg_data[11:0];
                default:             prop_gain_reg       <= prop_gain_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_IDLE;
            mode_reg      <= MODE_IDLE;
            integ_reg     <= '0;
            phase_reg     <= '0;
            tidx_reg      <= '0;
            seg_cnt_reg   <= '0;
            seg_odd_reg   <= 1'b0;
            buzz_rem_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            mode_reg      <= mode_next;
            integ_reg     <= integ_next;
            phase_reg     <= phase_next;
            tidx_reg      <= tidx_next;
            seg_cnt_reg   <= seg_cnt_next;
            seg_odd_reg   <= seg_odd_next;
            buzz_rem_reg  <= buzz_rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg     <= action_t'(action);
            new_mode_reg   <= new_mode;
            buzz_ticks_reg <= buzz_ticks;
            meas_reg       <= measured_current;
        end
        targ_reg         <= targ_next;
        err_reg          <= err_next;
        prod_reg         <= prod_next;
        sum_reg          <= sum_next;
        rom_addr_reg     <= rom_addr_next;
        duty_reg         <= duty_next;
        target_out_reg   <= target_out_next;
        mode_after_reg   <= mode_after_next;
        sample_valid_reg <= sample_valid_next;
        sample_index_reg <= sample_index_next;
    end

    always_ff @(posedge clk)
    begin
        if (uw.uop == U_ROM_READ)
            sine_reg <= sine_rom[rom_addr_reg];
    end

endmodule

>>> design/mcpic_checker.sv
// Port-level checker for the motor current PI mode controller, with its bind statement.
module mcpic_port_props
    import mcpic_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic signed [15:0]   duty,
    input logic signed [12:0]   target_current,
    input logic [1:0]           mode_after,
    input logic                 test_sample_valid,
    input logic [6:0]           test_sample_index
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(duty) && $stable(target_current)
                                   && $stable(mode_after) && $stable(test_sample_index))
        else $error("Stalled result item changed or was dropped.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Input accepted again before the previous item was processed.");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (duty <= DUTY_MAX) && (duty >= -DUTY_MAX))
        else $error("Duty outside the plus or minus full-scale range.");

    a_fixed_no_target: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mode_after == MODE_FIXED) |-> (target_current == '0) && !test_sample_valid)
        else $error("Fixed PWM item carries a target current or a test sample.");

    a_sample_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !test_sample_valid |-> (test_sample_index == '0))
        else $error("Sample index set on an item that is not a test sample.");

endmodule

bind motor_current_pi_mode_controller mcpic_port_props u_mcpic_port_props (.*);
